/* rtl/core/klt_pkg.sv */
// Shared types and constants of the key allowlist table.
// Request, result and memory control bundles used by the control and storage modules.
// No dependencies.
package klt_pkg;

    localparam int KEY_BYTES    = 32;
    localparam int KEY_W        = KEY_BYTES * 8;
    localparam int IDX_W        = 3;
    localparam int ENT_W        = 4;
    localparam int FUNC_W       = 2;
    localparam int MAX_KEYS_DEF = 8;

    // Stream widths: fields packed from the low end, filled up to whole bytes
    localparam int IN_DATA_W  = ((IDX_W + KEY_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((ENT_W + KEY_W + 7) / 8) * 8;

    typedef logic [KEY_W-1:0]  t_key;
    typedef logic [FUNC_W-1:0] t_func;

    localparam t_func FUNC_CHECK = 2'd0;
    localparam t_func FUNC_ADD   = 2'd1;
    localparam t_func FUNC_CLEAR = 2'd2;
    localparam t_func FUNC_GET   = 2'd3;

    typedef struct packed {
        t_func            func;
        logic [IDX_W-1:0] idx;
        t_key             key;
    } t_req;

    typedef struct packed {
        logic             ok;
        logic [ENT_W-1:0] entries;
        t_key             key;
    } t_res;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

endpackage

/* rtl/core/klt_key_mem.sv */
// Key storage of the allowlist table: one row of a full key per entry.
// One write port, one read port, read data registered. Depends on klt_pkg.
module klt_key_mem #(
    parameter int MAX_KEYS = klt_pkg::MAX_KEYS_DEF,
    localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1
) (
    input  logic                i_clk,
    input  klt_pkg::t_mem_ctl   i_ctl,
    input  logic [AW-1:0]       i_wr_addr,
    input  klt_pkg::t_key       i_wr_data,
    input  logic [AW-1:0]       i_rd_addr,
    output klt_pkg::t_key       o_rd_data
);
    import klt_pkg::*;

    t_key r_mem [MAX_KEYS];
    t_key r_rd_data;

    // The sequencer never reads and writes in the same cycle
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/core/klt_ctrl.sv */
// Sequencer of the allowlist table: key count, entry scan and result build.
// Drives the key memory one entry per cycle. Depends on klt_pkg.
module klt_ctrl #(
    parameter int MAX_KEYS = klt_pkg::MAX_KEYS_DEF,
    localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  klt_pkg::t_req       i_req,
    input  logic                i_slot_free,
    output logic                o_idle,
    output logic                o_done,
    output klt_pkg::t_res       o_res,
    output klt_pkg::t_mem_ctl   o_mem_ctl,
    output logic [AW-1:0]       o_wr_addr,
    output klt_pkg::t_key       o_wr_data,
    output logic [AW-1:0]       o_rd_addr,
    input  klt_pkg::t_key       i_rd_data
);
    import klt_pkg::*;

    localparam int CNT_W = $clog2(MAX_KEYS + 1);
    localparam int CW    = (CNT_W > IDX_W) ? CNT_W : IDX_W;
    localparam int EW    = (CNT_W > ENT_W) ? CNT_W : ENT_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_GET  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_ptr, n_ptr;
    t_func            r_func, n_func;
    t_key             r_key, n_key;
    t_res             r_res, n_res;

    t_func            cur_func;
    t_key             cur_key;
    logic             fin;
    logic             fin_hit;
    logic             hit;
    logic             add_acc;
    logic [CW-1:0]    idx_ext;
    logic [CW-1:0]    cnt_ext;
    logic [EW-1:0]    ent_ext;

    assign cur_func = (r_state == S_IDLE) ? i_req.func : r_func;
    assign cur_key  = (r_state == S_IDLE) ? i_req.key : r_key;
    assign hit      = (i_rd_data == r_key);
    assign idx_ext  = CW'(i_req.idx);
    assign cnt_ext  = CW'(r_count);
    assign ent_ext  = EW'(n_count);
    assign add_acc  = (cur_key != '0) && (r_count < CNT_W'(MAX_KEYS));

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_ptr     = r_ptr;
        n_func    = r_func;
        n_key     = r_key;
        n_res     = r_res;
        fin       = 1'b0;
        fin_hit   = 1'b0;
        o_done    = 1'b0;
        o_mem_ctl = '0;
        o_rd_addr = '0;
        o_wr_addr = r_count[AW-1:0];
        o_wr_data = cur_key;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_func = i_req.func;
                    n_key  = i_req.key;
                    case (i_req.func) inside
                        FUNC_CHECK, FUNC_ADD: begin
                            if (r_count == '0) begin
                                fin = 1'b1;
                            end else begin
                                o_mem_ctl.rd_en = 1'b1;
                                n_ptr   = CNT_W'(1);
                                n_state = S_SCAN;
                            end
                        end
                        FUNC_CLEAR: begin
                            n_count = '0;
                            n_res   = '{ok: 1'b1, entries: '0, key: '0};
                            n_state = S_DONE;
                        end
                        default: begin
                            if (idx_ext < cnt_ext) begin
                                o_mem_ctl.rd_en = 1'b1;
                                o_rd_addr = idx_ext[AW-1:0];
                                n_state   = S_GET;
                            end else begin
                                n_res   = '{ok: 1'b0, entries: '0, key: '0};
                                n_state = S_DONE;
                            end
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // Read data belongs to entry r_ptr-1; stop on a hit or after the last entry
                if (hit || (r_ptr == r_count)) begin
                    fin     = 1'b1;
                    fin_hit = hit;
                end else begin
                    o_mem_ctl.rd_en = 1'b1;
                    o_rd_addr = r_ptr[AW-1:0];
                    n_ptr     = r_ptr + CNT_W'(1);
                end
            end
            S_GET: begin
                n_res   = '{ok: 1'b1, entries: '0, key: i_rd_data};
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_slot_free) begin
                    o_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (fin) begin
            n_state   = S_DONE;
            n_res.key = '0;
            if (cur_func == FUNC_ADD) begin
                n_res.ok = add_acc && !fin_hit;
                if (add_acc && !fin_hit) begin
                    o_mem_ctl.wr_en = 1'b1;
                    n_count = r_count + CNT_W'(1);
                end
            end else begin
                n_res.ok = fin_hit || (r_count == '0);
            end
        end

        // Report the count left by this item
        if ((n_state == S_DONE) && (r_state != S_DONE)) begin
            n_res.entries = ent_ext[ENT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ptr   <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ptr   <= n_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func <= n_func;
        r_key  <= n_key;
        r_res  <= n_res;
    end

    assign o_idle = (r_state == S_IDLE);
    assign o_res  = r_res;

endmodule

/* rtl/core/key_allowlist_table_unit.sv */
// Top level of the key allowlist table: stream ports, output register,
// sequencer and key memory. Depends on klt_pkg, klt_ctrl and klt_key_mem.
//
//  channel  dir  fields                                         accepted when
//  s        in   tuser: func; tdata: index, key words 0..3      i_s_tvalid & o_s_tready
//  m        out  tuser: ok;   tdata: entries, out words 0..3    o_m_tvalid & i_m_tready
//
// One item at a time. Clear, empty-table check/add and an out-of-range get go from
// idle straight to the done state, a get through a read state; check and add scan
// stored entries one per cycle through the single memory read port, up to the key count.
// Reset (synchronous, active low) empties the table; memory contents are not cleared.
// A waiting result sits in the output register while the next item is taken;
// the sequencer holds its result until that register is free.
module key_allowlist_table_unit #(
    parameter int MAX_KEYS = klt_pkg::MAX_KEYS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // [2:0] index, [66:3] key_word0, [130:67] key_word1, [194:131] key_word2,
    // [258:195] key_word3, rest padding
    input  logic [klt_pkg::IN_DATA_W-1:0]    i_s_tdata,
    // [1:0] func
    input  logic [klt_pkg::FUNC_W-1:0]       i_s_tuser,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // [3:0] entries, [67:4] out_word0, [131:68] out_word1, [195:132] out_word2,
    // [259:196] out_word3, rest zero
    output logic [klt_pkg::OUT_DATA_W-1:0]   o_m_tdata,
    // [0] ok
    output logic [0:0]                       o_m_tuser
);
    import klt_pkg::*;

    localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;

    t_req          req;
    t_res          res;
    t_mem_ctl      mem_ctl;
    logic          idle;
    logic          done;
    logic          start;
    logic          slot_free;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    t_key          wr_data;
    t_key          rd_data;

    logic          r_out_valid;
    t_res          r_out;

    assign req.func = i_s_tuser;
    assign req.idx  = i_s_tdata[IDX_W-1:0];
    assign req.key  = i_s_tdata[IDX_W+KEY_W-1:IDX_W];

    assign o_s_tready = idle;
    assign start      = i_s_tvalid && idle;
    assign slot_free  = !r_out_valid || i_m_tready;

    klt_ctrl #(
        .MAX_KEYS (MAX_KEYS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_req       (req),
        .i_slot_free (slot_free),
        .o_idle      (idle),
        .o_done      (done),
        .o_res       (res),
        .o_mem_ctl   (mem_ctl),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data)
    );

    klt_key_mem #(
        .MAX_KEYS (MAX_KEYS)
    ) u_key_mem (
        .i_clk     (i_clk),
        .i_ctl     (mem_ctl),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.ok;
    assign o_m_tdata  = OUT_DATA_W'({r_out.key, r_out.entries});

endmodule
